[design/ois_pkg.sv]
// Shared types, constants and helper functions for the ordered index set.
// Used by the RAM-based datapath and its controller; no dependencies.
package ois_pkg;

    localparam int UNIVERSE = 1024;
    localparam int IDX_W    = 10;
    localparam int SIZE_W   = 11;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int WADDR_W  = IDX_W - BIT_W;
    localparam int WORDS    = UNIVERSE / WORD_W;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_ERASE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_NOTMEM = 2'd3;

    localparam logic REG_UNIVERSE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        K_DONE,
        K_CLEAR,
        K_HIT,
        K_SCAN
    } ois_kind_t;

    typedef struct packed {
        logic capture;
        logic issue_read;
        logic decide;
        logic scan_rd;
        logic scan_chk;
        logic rd_left;
        logic link1;
        logic link2;
        logic clear_wr;
        logic clear_fin;
        logic load_out;
    } ois_cmd_t;

    typedef struct packed {
        ois_kind_t kind;
        logic      scan_hit;
        logic      clr_last;
        logic      out_free;
    } ois_stat_t;

    function automatic logic [BIT_W-1:0] msb_pos(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[design/ois_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module ois_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/ois_datapath.sv]
// Datapath of the ordered index set: member mark words, link memories,
// list head and tail, result registers. Depends on ois_pkg and ois_ram.
module ois_datapath
    import ois_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ois_cmd_t          cmd,
    output ois_stat_t         stat,
    input  logic [SIZE_W-1:0] universe_size,
    input  logic [1:0]        func,
    input  logic [IDX_W-1:0]  element,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIZE_W-1:0] next_member,
    output logic [SIZE_W-1:0] first_member,
    output logic              set_empty,
    output logic [1:0]        status
);

    logic [1:0]         func_reg;
    logic [IDX_W-1:0]   e_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   last_reg;
    logic               empty_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [IDX_W-1:0]   left_reg;
    logic [WADDR_W-1:0] scan_reg;
    logic [WADDR_W-1:0] clr_cnt_reg;
    logic [1:0]         status_reg;
    logic [SIZE_W-1:0]  nxt_reg;
    logic               out_valid_reg;
    logic [SIZE_W-1:0]  next_member_reg;
    logic [SIZE_W-1:0]  first_member_reg;
    logic               set_empty_reg;
    logic [1:0]         status_out_reg;

    logic [SIZE_W-1:0]  size;
    logic [BIT_W-1:0]   bitpos;
    logic [WADDR_W-1:0] wsel;
    logic [WORD_W-1:0]  bitmask;
    logic [WORD_W-1:0]  below;
    logic [WORD_W-1:0]  mark_rd;
    logic [IDX_W-1:0]   next_rd;
    logic [IDX_W-1:0]   prev_rd;
    logic               is_mem;

    logic               mark_we;
    logic [WADDR_W-1:0] mark_waddr;
    logic [WORD_W-1:0]  mark_wdata;
    logic [WADDR_W-1:0] mark_raddr;
    logic               next_we;
    logic [IDX_W-1:0]   next_waddr;
    logic [IDX_W-1:0]   next_wdata;
    logic [IDX_W-1:0]   next_raddr;
    logic               prev_we;
    logic [IDX_W-1:0]   prev_waddr;
    logic [IDX_W-1:0]   prev_wdata;

    ois_kind_t          kind;
    logic [1:0]         st_c;
    logic [SIZE_W-1:0]  nxt_c;
    logic               ins_empty;
    logic               ins_front;
    logic               ins_back;
    logic               era_only;
    logic               era_first;
    logic               era_last;
    logic               era_mid;
    logic               mark_set;
    logic               mark_clr;

    always_comb
    begin
        if (universe_size == '0)
        begin
            size = SIZE_W'(1);
        end
        else if (universe_size > SIZE_W'(UNIVERSE))
        begin
            size = SIZE_W'(UNIVERSE);
        end
        else
        begin
            size = universe_size;
        end
    end

    assign bitpos  = e_reg[BIT_W-1:0];
    assign wsel    = e_reg[IDX_W-1:BIT_W];
    assign bitmask = WORD_W'(1) << bitpos;
    assign below   = mark_rd & (bitmask - WORD_W'(1));
    assign is_mem  = mark_rd[bitpos];

    always_comb
    begin
        kind      = K_DONE;
        st_c      = ST_OK;
        nxt_c     = '0;
        ins_empty = 1'b0;
        ins_front = 1'b0;
        ins_back  = 1'b0;
        era_only  = 1'b0;
        era_first = 1'b0;
        era_last  = 1'b0;
        era_mid   = 1'b0;
        mark_set  = 1'b0;
        mark_clr  = 1'b0;
        if (func_reg == FUNC_CLEAR)
        begin
            kind = K_CLEAR;
        end
        else if ({1'b0, e_reg} >= size)
        begin
            st_c = ST_RANGE;
        end
        else if (func_reg == FUNC_INSERT)
        begin
            if (is_mem)
            begin
                st_c = ST_DUP;
            end
            else if (empty_reg)
            begin
                ins_empty = 1'b1;
                mark_set  = 1'b1;
            end
            else if (e_reg < first_reg)
            begin
                ins_front = 1'b1;
                mark_set  = 1'b1;
            end
            else if (e_reg > last_reg)
            begin
                ins_back = 1'b1;
                mark_set = 1'b1;
            end
            else if (below != '0)
            begin
                kind = K_HIT;
            end
            else
            begin
                kind = K_SCAN;
            end
        end
        else if (!is_mem)
        begin
            st_c = ST_NOTMEM;
        end
        else if (func_reg == FUNC_ERASE)
        begin
            mark_clr = 1'b1;
            if (e_reg == first_reg && e_reg == last_reg)
            begin
                era_only = 1'b1;
            end
            else if (e_reg == first_reg)
            begin
                era_first = 1'b1;
            end
            else if (e_reg == last_reg)
            begin
                era_last = 1'b1;
            end
            else
            begin
                era_mid = 1'b1;
            end
        end
        else
        begin
            nxt_c = (e_reg == last_reg) ? size : {1'b0, next_rd};
        end
    end

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = wsel;
        mark_wdata = word_reg | bitmask;
        mark_raddr = cmd.scan_rd ? scan_reg : wsel;
        if (cmd.clear_wr)
        begin
            mark_we    = 1'b1;
            mark_waddr = clr_cnt_reg;
            mark_wdata = '0;
        end
        else if (cmd.decide && (mark_set || mark_clr))
        begin
            mark_we    = 1'b1;
            mark_wdata = mark_set ? (mark_rd | bitmask) : (mark_rd & ~bitmask);
        end
        else if (cmd.link2)
        begin
            mark_we = 1'b1;
        end
    end

    assign next_raddr = cmd.rd_left ? left_reg : e_reg;

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = e_reg;
        next_wdata = first_reg;
        prev_we    = 1'b0;
        prev_waddr = e_reg;
        prev_wdata = last_reg;
        if (cmd.decide)
        begin
            if (ins_front)
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                prev_waddr = first_reg;
                prev_wdata = e_reg;
            end
            else if (ins_back)
            begin
                next_we    = 1'b1;
                next_waddr = last_reg;
                next_wdata = e_reg;
                prev_we    = 1'b1;
            end
            else if (era_mid)
            begin
                next_we    = 1'b1;
                next_waddr = prev_rd;
                next_wdata = next_rd;
                prev_we    = 1'b1;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
            end
        end
        else if (cmd.link1)
        begin
            next_we    = 1'b1;
            next_wdata = next_rd;
            prev_we    = 1'b1;
            prev_wdata = left_reg;
        end
        else if (cmd.link2)
        begin
            next_we    = 1'b1;
            next_waddr = left_reg;
            next_wdata = e_reg;
            prev_we    = 1'b1;
            prev_waddr = next_rd;
            prev_wdata = e_reg;
        end
    end

    ois_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.issue_read || cmd.scan_rd),
        .raddr (mark_raddr),
        .rdata (mark_rd)
    );

    ois_ram #(.WIDTH(IDX_W), .DEPTH(UNIVERSE)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (cmd.issue_read || cmd.rd_left),
        .raddr (next_raddr),
        .rdata (next_rd)
    );

    ois_ram #(.WIDTH(IDX_W), .DEPTH(UNIVERSE)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (cmd.issue_read),
        .raddr (e_reg),
        .rdata (prev_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            last_reg      <= '0;
            empty_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + WADDR_W'(1);
            end
            if (cmd.clear_fin)
            begin
                empty_reg <= 1'b1;
                last_reg  <= '0;
            end
            if (cmd.decide)
            begin
                if (ins_empty)
                begin
                    first_reg <= e_reg;
                    last_reg  <= e_reg;
                    empty_reg <= 1'b0;
                end
                if (ins_front || era_first)
                begin
                    first_reg <= ins_front ? e_reg : next_rd;
                end
                if (ins_back || era_last)
                begin
                    last_reg <= ins_back ? e_reg : prev_rd;
                end
                if (era_only)
                begin
                    empty_reg <= 1'b1;
                    last_reg  <= '0;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            e_reg    <= element;
        end
        if (cmd.decide)
        begin
            status_reg <= st_c;
            nxt_reg    <= nxt_c;
            word_reg   <= mark_rd;
            left_reg   <= {wsel, msb_pos(below)};
            scan_reg   <= wsel - WADDR_W'(1);
        end
        if (cmd.scan_chk)
        begin
            if (mark_rd != '0)
            begin
                left_reg <= {scan_reg, msb_pos(mark_rd)};
            end
            else
            begin
                scan_reg <= scan_reg - WADDR_W'(1);
            end
        end
        if (cmd.clear_fin)
        begin
            status_reg <= ST_OK;
            nxt_reg    <= '0;
        end
        if (cmd.load_out)
        begin
            next_member_reg  <= nxt_reg;
            first_member_reg <= empty_reg ? size : {1'b0, first_reg};
            set_empty_reg    <= empty_reg;
            status_out_reg   <= status_reg;
        end
    end

    assign stat.kind     = kind;
    assign stat.scan_hit = (mark_rd != '0);
    assign stat.clr_last = (clr_cnt_reg == WADDR_W'(WORDS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign next_member  = next_member_reg;
    assign first_member = first_member_reg;
    assign set_empty    = set_empty_reg;
    assign status       = status_out_reg;

endmodule

[design/ois_ctrl.sv]
// Controller state machine of the ordered index set; sequences the datapath.
// Depends on ois_pkg.
module ois_ctrl
    import ois_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ois_stat_t stat,
    output ois_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RD_LEFT,
        S_LINK1,
        S_LINK2,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   clr_op_reg;
    logic   clr_op_next;

    always_comb
    begin
        state_next  = state_reg;
        clr_op_next = clr_op_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                unique case (stat.kind)
                    K_CLEAR:
                    begin
                        state_next  = S_CLEAR;
                        clr_op_next = 1'b1;
                    end
                    K_HIT:   state_next = S_RD_LEFT;
                    K_SCAN:  state_next = S_SCAN_RD;
                    default: state_next = S_DONE;
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = stat.scan_hit ? S_RD_LEFT : S_SCAN_RD;
            end
            S_RD_LEFT:
            begin
                state_next = S_LINK1;
            end
            S_LINK1:
            begin
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_op_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_op_reg <= clr_op_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign cmd.capture    = (state_reg == S_IDLE) && in_valid;
    assign cmd.issue_read = (state_reg == S_READ);
    assign cmd.decide     = (state_reg == S_DECIDE);
    assign cmd.scan_rd    = (state_reg == S_SCAN_RD);
    assign cmd.scan_chk   = (state_reg == S_SCAN_CHK);
    assign cmd.rd_left    = (state_reg == S_RD_LEFT);
    assign cmd.link1      = (state_reg == S_LINK1);
    assign cmd.link2      = (state_reg == S_LINK2);
    assign cmd.clear_wr   = (state_reg == S_CLEAR);
    assign cmd.clear_fin  = (state_reg == S_CLEAR) && stat.clr_last;
    assign cmd.load_out   = (state_reg == S_DONE) && stat.out_free;

endmodule

[design/ordered_index_set.sv]
// Top level of the ordered index set: configuration register, controller
// and datapath. Depends on ois_pkg, ois_ctrl and ois_datapath.
//
// The block keeps a set of indices as an ascending doubly linked list and
// answers one request at a time. Most requests pass the read, decide and
// done states; the result is registered and may wait while the next request
// is already being worked on. An insert that falls between the smallest and
// largest member also reads its left neighbour and writes two links, after
// searching the 32-bit words of member marks below the element, up to 31
// words, if its own word holds no smaller member. A clear request, and the
// period after reset, sweep the 32 words of the member mark memory, during
// which no request is accepted; register writes are taken at any time.
module ordered_index_set
    import ois_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [IDX_W-1:0]  element,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIZE_W-1:0] next_member,
    output logic [SIZE_W-1:0] first_member,
    output logic              set_empty,
    output logic [1:0]        status
);

    logic [SIZE_W-1:0] universe_size_reg;
    ois_cmd_t          cmd;
    ois_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            universe_size_reg <= SIZE_W'(UNIVERSE);
        end
        else if (psel && penable && pwrite && paddr[2] == REG_UNIVERSE_SIZE)
        begin
            universe_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNIVERSE_SIZE) ? {21'b0, universe_size_reg} : 32'b0;

    ois_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ois_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .universe_size (universe_size_reg),
        .func          (func),
        .element       (element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .next_member   (next_member),
        .first_member  (first_member),
        .set_empty     (set_empty),
        .status        (status)
    );

endmodule

[design/ois_checker.sv]
// Port-level checks for the ordered index set, bound to the top level.
// Depends on ois_pkg and ordered_index_set.
module ois_checker
    import ois_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SIZE_W-1:0] next_member,
    input logic [SIZE_W-1:0] first_member,
    input logic              set_empty,
    input logic [1:0]        status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(next_member) && $stable(first_member))
        else $error("result changed while stalled");

    a_fail_no_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> next_member == '0)
        else $error("rejected request reports a next member");

    a_first_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !set_empty |-> first_member[SIZE_W-1] == 1'b0)
        else $error("first member of a non-empty set is out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

endmodule

bind ordered_index_set ois_checker u_ois_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for ordered_index_set: directed table, then random
// insert/erase/query/clear requests checked against a behavioral list model.
// Depends on ois_pkg and the ordered_index_set RTL.
module tb_top;
    import ois_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]        fn;
        logic [IDX_W-1:0]  el;
        logic [SIZE_W-1:0] nm;
        logic [SIZE_W-1:0] fm;
        logic              em;
        logic [1:0]        st;
    } set_resp_t;

    typedef struct {
        logic [1:0]       fn;
        logic [IDX_W-1:0] el;
        bit               typed;
        logic [SIZE_W-1:0] nm;
        logic [SIZE_W-1:0] fm;
        logic             em;
        logic [1:0]       st;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] func = FUNC_CLEAR;
    logic [IDX_W-1:0] element = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SIZE_W-1:0] next_member, first_member;
    logic set_empty;
    logic [1:0] status;

    ordered_index_set u_top (.*);

    always #1 clk = ~clk;

    // Predictor state.
    logic [SIZE_W-1:0] size_reg;
    bit                mark [UNIVERSE];
    logic [SIZE_W-1:0] nxt_l [UNIVERSE];
    logic [SIZE_W-1:0] prv_l [UNIVERSE];
    logic [SIZE_W-1:0] head, tail;
    bit                empty;

    set_resp_t pending_q[$];
    int errors = 0;
    int n_req = 0, n_resp = 0;
    bit stall_mode = 0;

    function automatic logic [SIZE_W-1:0] eff_sz();
        if (size_reg < 1) return SIZE_W'(1);
        if (size_reg > UNIVERSE) return SIZE_W'(UNIVERSE);
        return size_reg;
    endfunction

    function automatic void wipe_set();
        for (int i = 0; i < UNIVERSE; i++) mark[i] = 0;
        empty = 1;
        head = eff_sz();
        tail = '0;
    endfunction

    function automatic set_resp_t predict_set(logic [1:0] fn, logic [IDX_W-1:0] e);
        set_resp_t r;
        logic [SIZE_W-1:0] sz, lft, rgt, p, n, ex;
        int i;
        sz = eff_sz();
        ex = {1'b0, e};
        r.fn = fn;
        r.el = e;
        r.nm = '0;
        r.st = ST_OK;
        if (fn == FUNC_CLEAR) wipe_set();
        else if (ex >= sz) r.st = ST_RANGE;
        else if (fn == FUNC_INSERT)
        begin
            if (mark[e]) r.st = ST_DUP;
            else
            begin
                if (empty)
                begin
                    head = ex;
                    tail = ex;
                    empty = 0;
                end
                else if (ex < head)
                begin
                    if (head < UNIVERSE) prv_l[head] = ex;
                    nxt_l[e] = head;
                    head = ex;
                end
                else if (ex > tail)
                begin
                    prv_l[e] = tail;
                    nxt_l[tail] = ex;
                    tail = ex;
                end
                else
                begin
                    lft = ex;
                    for (i = int'(e) - 1; i >= 0; i--)
                    begin
                        if (mark[i])
                        begin
                            lft = SIZE_W'(i);
                            break;
                        end
                    end
                    rgt = (lft < UNIVERSE) ? nxt_l[lft] : '0;
                    if (rgt < UNIVERSE) prv_l[rgt] = ex;
                    nxt_l[e] = rgt;
                    prv_l[e] = lft;
                    if (lft < UNIVERSE) nxt_l[lft] = ex;
                end
                mark[e] = 1;
            end
        end
        else if (!mark[e]) r.st = ST_NOTMEM;
        else if (fn == FUNC_ERASE)
        begin
            if (ex == head && ex == tail)
            begin
                empty = 1;
                head = sz;
                tail = '0;
            end
            else if (ex == head) head = nxt_l[e];
            else if (ex == tail) tail = prv_l[e];
            else
            begin
                p = prv_l[e];
                n = nxt_l[e];
                if (n < UNIVERSE) prv_l[n] = p;
                if (p < UNIVERSE) nxt_l[p] = n;
            end
            mark[e] = 0;
        end
        else r.nm = (ex == tail) ? sz : nxt_l[e];
        r.fm = empty ? sz : head;
        r.em = empty;
        return r;
    endfunction

    task automatic write_size(input logic [31:0] v);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 3'(4 * REG_UNIVERSE_SIZE); pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        size_reg = v[SIZE_W-1:0];
    endtask

    // Valid stays high after acceptance until the next request or a gap
    // replaces it, so each call drives every input exactly once.
    task automatic send_req(input logic [1:0] fn, input logic [IDX_W-1:0] e,
                            input bit typed, input set_resp_t exp_r);
        set_resp_t r;
        func <= fn;
        element <= e;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = predict_set(fn, e);
        if (typed && (r.nm !== exp_r.nm || r.fm !== exp_r.fm || r.em !== exp_r.em
                      || r.st !== exp_r.st))
        begin
            $display("%0t row fn=%0d el=%0d: typed %0d/%0d/%0d/%0d model %0d/%0d/%0d/%0d",
                     $time, fn, e, exp_r.nm, exp_r.fm, exp_r.em, exp_r.st,
                     r.nm, r.fm, r.em, r.st);
            errors++;
        end
        pending_q.push_back(r);
        n_req++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic burst_gap();
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Receiver with its own stall pattern.
    always @(negedge clk)
    begin
        if (stall_mode) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= 1;
    end

    always @(posedge clk)
    begin
        set_resp_t x;
        if (rst_n && out_valid && out_ready)
        begin
            n_resp++;
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected result nm=%0d fm=%0d em=%0d st=%0d",
                         $time, next_member, first_member, set_empty, status);
                errors++;
            end
            else
            begin
                x = pending_q.pop_front();
                if (next_member !== x.nm || first_member !== x.fm ||
                    set_empty !== x.em || status !== x.st)
                begin
                    $display("%0t mismatch fn=%0d el=%0d exp %0d/%0d/%0d/%0d",
                             $time, x.fn, x.el, x.nm, x.fm, x.em, x.st);
                    $display("    got %0d/%0d/%0d/%0d",
                             next_member, first_member, set_empty, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        dir_row_t tbl[$];
        set_resp_t er;
        int sizes[6];
        logic [1:0] fn;
        logic [IDX_W-1:0] e;
        logic [SIZE_W-1:0] sz;
        int k;
        size_reg = SIZE_W'(UNIVERSE);
        wipe_set();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        tbl.push_back('{FUNC_QUERY, 0, 1, 0, 1024, 1, ST_NOTMEM});
        tbl.push_back('{FUNC_ERASE, 1023, 1, 0, 1024, 1, ST_NOTMEM});
        tbl.push_back('{FUNC_INSERT, 1023, 1, 0, 1023, 0, ST_OK});
        tbl.push_back('{FUNC_INSERT, 1023, 1, 0, 1023, 0, ST_DUP});
        tbl.push_back('{FUNC_QUERY, 1023, 1, 1024, 1023, 0, ST_OK});
        tbl.push_back('{FUNC_INSERT, 0, 1, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_QUERY, 0, 1, 1023, 0, 0, ST_OK});
        tbl.push_back('{FUNC_INSERT, 512, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_INSERT, 700, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_INSERT, 31, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_QUERY, 512, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_ERASE, 512, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_ERASE, 0, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_ERASE, 1023, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_QUERY, 700, 0, 0, 0, 0, ST_OK});
        tbl.push_back('{FUNC_CLEAR, 0, 1, 0, 1024, 1, ST_OK});
        tbl.push_back('{FUNC_INSERT, 5, 1, 0, 5, 0, ST_OK});
        tbl.push_back('{FUNC_ERASE, 5, 1, 0, 1024, 1, ST_OK});
        tbl.push_back('{FUNC_CLEAR, 1023, 1, 0, 1024, 1, ST_OK});
        foreach (tbl[i])
        begin
            er = '{tbl[i].fn, tbl[i].el, tbl[i].nm, tbl[i].fm, tbl[i].em, tbl[i].st};
            send_req(tbl[i].fn, tbl[i].el, tbl[i].typed, er);
        end
        drain();

        // Size extremes: a shrink leaves high members reported but unaddressable.
        write_size(1);
        send_req(FUNC_INSERT, 1, 0, er);
        send_req(FUNC_INSERT, 0, 0, er);
        send_req(FUNC_QUERY, 0, 0, er);
        drain();
        write_size(0);
        send_req(FUNC_INSERT, 0, 0, er);
        send_req(FUNC_CLEAR, 0, 0, er);
        drain();
        write_size(2047);
        send_req(FUNC_INSERT, 1023, 0, er);
        send_req(FUNC_INSERT, 600, 0, er);
        drain();
        write_size(300);
        send_req(FUNC_QUERY, 600, 0, er);
        send_req(FUNC_INSERT, 100, 0, er);
        send_req(FUNC_QUERY, 100, 0, er);
        drain();

        sizes = '{1024, 64, 2, 1000, 37, 1024};
        stall_mode = 1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_size(32'(sizes[ph]));
            sz = eff_sz();
            for (k = 0; k < 135; k++)
            begin
                burst_gap();
                case ($urandom_range(0, 19))
                    0: fn = FUNC_CLEAR;
                    1, 2, 3, 4, 5, 6, 7, 8, 9: fn = FUNC_INSERT;
                    10, 11, 12, 13, 14: fn = FUNC_ERASE;
                    default: fn = FUNC_QUERY;
                endcase
                if ($urandom_range(0, 15) == 0) e = IDX_W'($urandom());
                else if (ph == 0 && $urandom_range(0, 1)) e = IDX_W'($urandom());
                else e = IDX_W'($urandom_range(0, int'(sz) - 1));
                send_req(fn, e, 0, er);
            end
            drain();
        end
        drain();
        $display("Covered %0d requests and %0d results over several universe sizes,",
                 n_req, n_resp);
        $display("with random sender gaps and receiver stalls.");
        if (errors == 0 && pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
